>>> hw/rtl/ncr_dec_pkg.sv
// Shared types, status codes and the Windows-1252 remap table for the
// numeric character reference decoder. No dependencies.
`timescale 1ns / 1ps

package ncr_dec_pkg;

    // Result status codes
    localparam logic [1:0] STATUS_DECODED   = 2'd0;
    localparam logic [1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [1:0] STATUS_NAMED     = 2'd2;

    // One input transaction
    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_reference;
    } char_t;

    // One output transaction
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] utf8_byte;
        logic       byte_valid;
        logic       last_of_run;
    } result_t;

    // Finished reference, waiting to be sent as 1 to 4 results
    typedef struct packed {
        logic [1:0]      status;
        logic [3:0][7:0] bytes;     // bytes[0] goes out first
        logic [1:0]      last_idx;  // index of the final result
    } pending_t;

    // Code points U+0080..U+009F seen through Windows-1252
    function automatic logic [15:0] cp1252_high(input logic [4:0] idx);
        logic [15:0] cp;
        case (idx)
            5'd0:    cp = 16'h20AC;
            5'd1:    cp = 16'h0081;
            5'd2:    cp = 16'h201A;
            5'd3:    cp = 16'h0192;
            5'd4:    cp = 16'h201E;
            5'd5:    cp = 16'h2026;
            5'd6:    cp = 16'h2020;
            5'd7:    cp = 16'h2021;
            5'd8:    cp = 16'h02C6;
            5'd9:    cp = 16'h2030;
            5'd10:   cp = 16'h0160;
            5'd11:   cp = 16'h2039;
            5'd12:   cp = 16'h0152;
            5'd13:   cp = 16'h008D;
            5'd14:   cp = 16'h017D;
            5'd15:   cp = 16'h008F;
            5'd16:   cp = 16'h0090;
            5'd17:   cp = 16'h2018;
            5'd18:   cp = 16'h2019;
            5'd19:   cp = 16'h201C;
            5'd20:   cp = 16'h201D;
            5'd21:   cp = 16'h2022;
            5'd22:   cp = 16'h2013;
            5'd23:   cp = 16'h2014;
            5'd24:   cp = 16'h02DC;
            5'd25:   cp = 16'h2122;
            5'd26:   cp = 16'h0161;
            5'd27:   cp = 16'h203A;
            5'd28:   cp = 16'h0153;
            5'd29:   cp = 16'h009D;
            5'd30:   cp = 16'h017E;
            default: cp = 16'h0178;
        endcase
        return cp;
    endfunction

endpackage

>>> hw/rtl/ncr_dec_parser.sv
// Reference parser: phase, base and accumulated code point, plus the
// final-byte decision with UTF-8 encoding. Depends on ncr_dec_pkg.
`timescale 1ns / 1ps

module ncr_dec_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,      // transaction accepted this cycle
    input  ncr_dec_pkg::char_t    char_in,
    output ncr_dec_pkg::pending_t finish     // valid when take and end flag
);

    localparam logic [2:0] PH_AMP    = 3'd0;
    localparam logic [2:0] PH_HASH   = 3'd1;
    localparam logic [2:0] PH_BASE   = 3'd2;
    localparam logic [2:0] PH_FIRSTD = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_ERROR  = 3'd5;
    localparam logic [2:0] PH_NAMED  = 3'd6;

    localparam logic [20:0] SAT_LIMIT = 21'h110000;
    localparam logic [20:0] HEX_LIMIT = 21'h011000;   // SAT_LIMIT / 16
    localparam logic [20:0] DEC_LIMIT = 21'd111411;   // SAT_LIMIT / 10

    logic [2:0]  phase_reg, phase_next;
    logic        hex_reg, hex_next;
    logic [20:0] acc_reg, acc_next;

    logic [7:0]  c;
    logic        is_dec, is_hex_lo, is_hex_up, digit_ok;
    logic [3:0]  digit;
    logic [20:0] acc_step;
    logic [24:0] acc_mul;

    logic [20:0] cp_raw, cp_map, cp_fin;

    assign c = char_in.char_byte;

    // digit decode
    always_comb
    begin
        is_dec    = (c inside {["0":"9"]});
        is_hex_lo = (c inside {["a":"f"]});
        is_hex_up = (c inside {["A":"F"]});
        digit_ok  = is_dec || (hex_reg && (is_hex_lo || is_hex_up));
        if (is_dec)
            digit = 4'(c - 8'h30);
        else if (is_hex_lo)
            digit = 4'(c - 8'h57);
        else
            digit = 4'(c - 8'h37);
    end

    // saturating multiply-accumulate; x10 is two shifts and an add
    always_comb
    begin
        if (hex_reg)
            acc_mul = {acc_reg, 4'b0000} + 25'(digit);
        else
            acc_mul = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + 25'(digit);
        if (acc_reg > (hex_reg ? HEX_LIMIT : DEC_LIMIT))
            acc_step = SAT_LIMIT;
        else
            acc_step = acc_mul[20:0];
    end

    always_comb
    begin
        phase_next = phase_reg;
        hex_next   = hex_reg;
        acc_next   = acc_reg;
        if (take)
        begin
            if (char_in.end_of_reference)
            begin
                phase_next = PH_AMP;
                hex_next   = 1'b0;
                acc_next   = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_AMP:
                        phase_next = (c == "&") ? PH_HASH : PH_ERROR;
                    PH_HASH:
                        phase_next = (c == "#") ? PH_BASE : PH_NAMED;
                    PH_BASE:
                    begin
                        if (c == "x" || c == "X")
                        begin
                            hex_next   = 1'b1;
                            phase_next = PH_FIRSTD;
                        end
                        else if (digit_ok)
                        begin
                            acc_next   = acc_step;
                            phase_next = PH_DIGITS;
                        end
                        else
                            phase_next = PH_ERROR;
                    end
                    PH_FIRSTD, PH_DIGITS:
                    begin
                        if (digit_ok)
                        begin
                            acc_next   = acc_step;
                            phase_next = PH_DIGITS;
                        end
                        else
                            phase_next = PH_ERROR;
                    end
                    PH_NAMED:
                        phase_next = PH_NAMED;
                    default:
                        phase_next = PH_ERROR;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_AMP;
            hex_reg   <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            hex_reg   <= hex_next;
            acc_reg   <= acc_next;
        end
    end

    // code point cleanup: C1 remap, then invalid values to U+FFFD
    always_comb
    begin
        cp_raw = acc_reg;
        if (cp_raw inside {[21'h80:21'h9F]})
            cp_map = {5'b0, ncr_dec_pkg::cp1252_high(cp_raw[4:0])};
        else
            cp_map = cp_raw;
        if (cp_map == '0 || cp_map > 21'h10FFFF || (cp_map inside {[21'hD800:21'hDFFF]}))
            cp_fin = 21'h00FFFD;
        else
            cp_fin = cp_map;
    end

    // UTF-8 encode and status decision
    always_comb
    begin
        finish.bytes = '0;
        if (cp_fin < 21'h80)
        begin
            finish.bytes[0] = cp_fin[7:0];
            finish.last_idx = 2'd0;
        end
        else if (cp_fin < 21'h800)
        begin
            finish.bytes[0] = {3'b110, cp_fin[10:6]};
            finish.bytes[1] = {2'b10, cp_fin[5:0]};
            finish.last_idx = 2'd1;
        end
        else if (cp_fin < 21'h10000)
        begin
            finish.bytes[0] = {4'b1110, cp_fin[15:12]};
            finish.bytes[1] = {2'b10, cp_fin[11:6]};
            finish.bytes[2] = {2'b10, cp_fin[5:0]};
            finish.last_idx = 2'd2;
        end
        else
        begin
            finish.bytes[0] = {5'b11110, cp_fin[20:18]};
            finish.bytes[1] = {2'b10, cp_fin[17:12]};
            finish.bytes[2] = {2'b10, cp_fin[11:6]};
            finish.bytes[3] = {2'b10, cp_fin[5:0]};
            finish.last_idx = 2'd3;
        end

        if (c != ";")
            finish.status = ncr_dec_pkg::STATUS_MALFORMED;
        else if (phase_reg == PH_DIGITS)
            finish.status = ncr_dec_pkg::STATUS_DECODED;
        else if (phase_reg == PH_NAMED)
            finish.status = ncr_dec_pkg::STATUS_NAMED;
        else
            finish.status = ncr_dec_pkg::STATUS_MALFORMED;

        // error and named outcomes are a single result
        if (finish.status != ncr_dec_pkg::STATUS_DECODED)
            finish.last_idx = 2'd0;
    end

endmodule

>>> hw/rtl/ncr_dec_out_stage.sv
// Pending-reference holding register and output register; walks the
// 1 to 4 results of a finished reference. Depends on ncr_dec_pkg.
`timescale 1ns / 1ps

module ncr_dec_out_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,          // new finished reference
    input  ncr_dec_pkg::pending_t pend,
    output logic                  busy,          // cannot take a load now
    output logic                  result_valid,
    input  logic                  result_stall,
    output ncr_dec_pkg::result_t  result_data
);

    logic                  p_valid_reg;
    ncr_dec_pkg::pending_t p_data_reg;
    logic [1:0]            p_idx_reg;

    logic                  out_valid_reg;
    ncr_dec_pkg::result_t  out_data_reg;

    logic                  out_free, move, p_drain;
    ncr_dec_pkg::result_t  elem;

    assign out_free = !out_valid_reg || !result_stall;
    assign move     = p_valid_reg && out_free;
    assign p_drain  = move && (p_idx_reg == p_data_reg.last_idx);
    assign busy     = p_valid_reg && !p_drain;

    always_comb
    begin
        elem.status      = p_data_reg.status;
        elem.byte_valid  = (p_data_reg.status == ncr_dec_pkg::STATUS_DECODED);
        elem.utf8_byte   = elem.byte_valid ? p_data_reg.bytes[p_idx_reg] : 8'h00;
        elem.last_of_run = (p_idx_reg == p_data_reg.last_idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            p_idx_reg   <= '0;
        end
        else if (load)
        begin
            p_valid_reg <= 1'b1;
            p_idx_reg   <= '0;
        end
        else if (p_drain)
            p_valid_reg <= 1'b0;
        else if (move)
            p_idx_reg <= p_idx_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            p_data_reg <= pend;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (move)
            out_valid_reg <= 1'b1;
        else if (!result_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (move)
            out_data_reg <= elem;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    // a new reference never overwrites one still being sent
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !busy)
        else $error("pending reference overwritten");

    // walk index stays within the run
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> (p_idx_reg <= p_data_reg.last_idx))
        else $error("result index past end of run");

    // status results are single, byte-less transactions
    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.status != ncr_dec_pkg::STATUS_DECODED)
        |-> (result_data.last_of_run && !result_data.byte_valid))
        else $error("error result not a single transaction");

    // a result that was taken is replaced or dropped, never sent twice
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && !move) |=> !result_valid)
        else $error("result repeated");

endmodule

>>> hw/rtl/numeric_char_reference_decoder.sv
// Top level of the numeric character reference decoder.
// Depends on ncr_dec_pkg, ncr_dec_parser and ncr_dec_out_stage.
`timescale 1ns / 1ps

// Usage:
//   Input channel (char_valid / char_stall / char_data) carries one byte of
//   a reference per transaction, end_of_reference set on its final byte.
//   Output channel (result_valid / result_stall / result_data) carries the
//   results: 1 to 4 UTF-8 bytes for a decoded reference, or one byte-less
//   transaction with a malformed or named-reference status.
// Throughput: one input byte per cycle. Bytes that are not final are always
//   taken. A final byte is held off only while the previous reference still
//   has results queued that will not leave this cycle; the single pending
//   slot drains one result per cycle while the receiver does not stall.
// Result path: the first result of a reference passes through the pending
//   slot, then the output register, after its final byte is accepted.
// Reset (rst_n low, asynchronous): parser returns to expecting '&', base and
//   accumulator clear, pending slot and output register empty.
// Receiver stall: the output register holds its transaction unchanged; the
//   pending slot waits behind it, and only a further final byte is stalled.
module numeric_char_reference_decoder
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_stall,
    input  ncr_dec_pkg::char_t   char_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output ncr_dec_pkg::result_t result_data
);

    logic                  take;
    logic                  busy;
    ncr_dec_pkg::pending_t finish;

    // only a final byte needs the pending slot
    assign char_stall = char_data.end_of_reference && busy;
    assign take       = char_valid && !char_stall;

    ncr_dec_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .char_in (char_data),
        .finish  (finish)
    );

    ncr_dec_out_stage u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (take && char_data.end_of_reference),
        .pend         (finish),
        .busy         (busy),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

>>> tb/sv/tb_numeric_char_reference_decoder.sv
// Self-checking testbench for numeric_char_reference_decoder: directed and random
// character references, random idling on both sides, and a long receiver hold-off.
// Depends on ncr_dec_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_numeric_char_reference_decoder;

    // Windows-1252 view of U+0080..U+009F, entry 0 in the low 16 bits
    localparam logic [511:0] WIN1252 = {
        16'h0178, 16'h017E, 16'h009D, 16'h0153, 16'h203A, 16'h0161, 16'h2122, 16'h02DC,
        16'h2014, 16'h2013, 16'h2022, 16'h201D, 16'h201C, 16'h2019, 16'h2018, 16'h0090,
        16'h008F, 16'h017D, 16'h008D, 16'h0152, 16'h2039, 16'h0160, 16'h2030, 16'h02C6,
        16'h2021, 16'h2020, 16'h2026, 16'h201E, 16'h0192, 16'h201A, 16'h0081, 16'h20AC
    };
    localparam logic [20:0] SAT_CODE    = 21'h110000;
    localparam logic [20:0] MAX_CODE    = 21'h10FFFF;
    localparam logic [20:0] REPLACEMENT = 21'h00FFFD;

    // Parser position inside one reference
    typedef enum logic [2:0] {
        AT_AMP,
        AT_HASH,
        AT_BASE,
        AT_FIRST_DIGIT,
        AT_DIGITS,
        AT_BROKEN,
        AT_NAMED
    } ref_phase_e;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 char_valid = 1'b0;
    logic                 char_stall;
    ncr_dec_pkg::char_t   char_data = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    ncr_dec_pkg::result_t result_data;

    // Predictor state, a private copy of the parser registers
    ref_phase_e  ref_phase = AT_AMP;
    logic        ref_hex = 1'b0;
    logic [20:0] ref_code = '0;

    ncr_dec_pkg::result_t decoded_q[$];    // results owed by the DUT, oldest first
    logic [7:0]           ref_text[$];     // reference being assembled for sending

    int mismatch_count = 0;
    int chars_sent = 0;
    int results_seen = 0;
    int refs_decoded = 0;
    int refs_malformed = 0;
    int refs_named = 0;

    // Idling controls: quiet flags switch random idling off, hold counts stall cycles
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int rx_hold_ask = 0;
    int rx_hold_left = 0;

    numeric_char_reference_decoder i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_data    (char_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int digit_value(logic [7:0] c, logic hex);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (hex && c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (hex && c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic void owe_status(logic [1:0] st);
        ncr_dec_pkg::result_t r;
        r.status      = st;
        r.utf8_byte   = 8'h00;
        r.byte_valid  = 1'b0;
        r.last_of_run = 1'b1;
        decoded_q.push_back(r);
    endfunction

    // Remap, sanitize, then split the code point into UTF-8 bytes
    function automatic void owe_code_point(logic [20:0] code_in);
        logic [20:0]          cp;
        logic [7:0]           utf8 [0:3];
        int                   n;
        ncr_dec_pkg::result_t r;
        cp = code_in;
        if (cp >= 21'h80 && cp <= 21'h9F)
            cp = {5'b0, WIN1252[{cp[4:0], 4'b0000} +: 16]};
        if (cp == 21'h0 || cp > MAX_CODE || (cp >= 21'hD800 && cp <= 21'hDFFF))
            cp = REPLACEMENT;
        if (cp < 21'h80)
        begin
            utf8[0] = cp[7:0];
            n = 1;
        end
        else if (cp < 21'h800)
        begin
            utf8[0] = {3'b110, cp[10:6]};
            utf8[1] = {2'b10, cp[5:0]};
            n = 2;
        end
        else if (cp < 21'h10000)
        begin
            utf8[0] = {4'b1110, cp[15:12]};
            utf8[1] = {2'b10, cp[11:6]};
            utf8[2] = {2'b10, cp[5:0]};
            n = 3;
        end
        else
        begin
            utf8[0] = {5'b11110, cp[20:18]};
            utf8[1] = {2'b10, cp[17:12]};
            utf8[2] = {2'b10, cp[11:6]};
            utf8[3] = {2'b10, cp[5:0]};
            n = 4;
        end
        for (int k = 0; k < n; k++)
        begin
            r.status      = ncr_dec_pkg::STATUS_DECODED;
            r.utf8_byte   = utf8[k];
            r.byte_valid  = 1'b1;
            r.last_of_run = (k == n - 1);
            decoded_q.push_back(r);
        end
    endfunction

    // One accepted character: advance the parser, on the final byte owe results
    function automatic void decode_step(ncr_dec_pkg::char_t c);
        int          d;
        logic [31:0] radix;
        logic [31:0] grown;
        if (c.end_of_reference)
        begin
            if (c.char_byte != ";")
                owe_status(ncr_dec_pkg::STATUS_MALFORMED);
            else if (ref_phase == AT_DIGITS)
                owe_code_point(ref_code);
            else if (ref_phase == AT_NAMED)
                owe_status(ncr_dec_pkg::STATUS_NAMED);
            else
                owe_status(ncr_dec_pkg::STATUS_MALFORMED);
            ref_phase = AT_AMP;
            ref_hex   = 1'b0;
            ref_code  = '0;
            return;
        end
        case (ref_phase)
            AT_AMP:
                ref_phase = (c.char_byte == "&") ? AT_HASH : AT_BROKEN;
            AT_HASH:
                ref_phase = (c.char_byte == "#") ? AT_BASE : AT_NAMED;
            AT_BASE, AT_FIRST_DIGIT, AT_DIGITS:
            begin
                if (ref_phase == AT_BASE && (c.char_byte == "x" || c.char_byte == "X"))
                begin
                    ref_hex   = 1'b1;
                    ref_phase = AT_FIRST_DIGIT;
                end
                else
                begin
                    // ref_hex is still clear while the base is open
                    d = digit_value(c.char_byte, ref_hex);
                    if (d < 0)
                        ref_phase = AT_BROKEN;
                    else
                    begin
                        radix = ref_hex ? 32'd16 : 32'd10;
                        if (32'(ref_code) > 32'(SAT_CODE) / radix)
                            ref_code = SAT_CODE;
                        else
                        begin
                            grown    = 32'(ref_code) * radix + 32'(d);
                            ref_code = grown[20:0];
                        end
                        ref_phase = AT_DIGITS;
                    end
                end
            end
            AT_NAMED:
                ;
            default:
                ref_phase = AT_BROKEN;
        endcase
    endfunction

    // Input monitor: predict from every accepted character
    always @(posedge clk)
    begin
        if (rst_n && char_valid && !char_stall)
            decode_step(char_data);
    end

    // ------------------------------------------------------------------
    // Receiver: random stall, plus long hold-offs counted here
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rx_hold_ask != 0)
        begin
            rx_hold_left = rx_hold_ask;
            rx_hold_ask  = 0;
        end
        if (rx_hold_left != 0)
        begin
            result_stall <= 1'b1;
            rx_hold_left = rx_hold_left - 1;
        end
        else
            result_stall <= !rx_quiet && ($urandom_range(0, 99) < 8);
    end

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Output checker: each accepted result against the oldest expectation
    always @(posedge clk)
    begin : check_results
        ncr_dec_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (decoded_q.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time,
                         result_data);
            end
            else
            begin
                want = decoded_q.pop_front();
                check_field("status", 8'(want.status), 8'(result_data.status));
                check_field("utf8_byte", want.utf8_byte, result_data.utf8_byte);
                check_field("byte_valid", 8'(want.byte_valid), 8'(result_data.byte_valid));
                check_field("last_of_run", 8'(want.last_of_run),
                            8'(result_data.last_of_run));
            end
            if (result_data.last_of_run)
            begin
                if (result_data.status == ncr_dec_pkg::STATUS_DECODED)
                    refs_decoded++;
                else if (result_data.status == ncr_dec_pkg::STATUS_MALFORMED)
                    refs_malformed++;
                else if (result_data.status == ncr_dec_pkg::STATUS_NAMED)
                    refs_named++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // One character transaction; entered and left at a rising edge. Valid stays
    // high afterwards so back-to-back characters keep the input busy.
    task automatic send_char(logic [7:0] b, logic last);
        if (!tx_quiet && $urandom_range(0, 99) < 6)
        begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        char_valid <= 1'b1;
        char_data  <= '{char_byte: b, end_of_reference: last};
        do
            @(posedge clk);
        while (char_stall);
        chars_sent++;
    endtask

    task automatic send_ref_text();
        int n;
        n = ref_text.size();
        for (int i = 0; i < n; i++)
            send_char(ref_text[i], i == n - 1);
        ref_text.delete();
    endtask

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++)
            ref_text.push_back(s[i]);
    endtask

    // Digits of a value, with occasional leading zeros and mixed-case hex
    task automatic add_number(logic [20:0] value, bit hex);
        string      s;
        logic [7:0] ch;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) ref_text.push_back("0");
        s = hex ? $sformatf("%0h", value) : $sformatf("%0d", value);
        for (int i = 0; i < s.len(); i++)
        begin
            ch = s[i];
            if (ch >= "a" && ch <= "f" && $urandom_range(0, 1))
                ch = ch - 8'h20;
            ref_text.push_back(ch);
        end
    endtask

    // A well-formed numeric reference, value drawn from the interesting ranges
    task automatic add_wellformed();
        bit          hex;
        logic [20:0] v;
        string       hex_chars;
        hex_chars = "0123456789abcdefABCDEF";
        hex = 1'($urandom_range(0, 1));
        add_str("&#");
        if (hex)
            ref_text.push_back($urandom_range(0, 1) ? "x" : "X");
        case ($urandom_range(0, 9))
            0: v = 21'($urandom_range(1, 'h7F));
            1: v = 21'($urandom_range('h80, 'h9F));
            2: v = '0;
            3: v = 21'($urandom_range('hD800, 'hDFFF));
            4: v = 21'($urandom_range('hA0, 'h7FF));
            5: v = 21'($urandom_range('h800, 'hFFFF));
            6: v = 21'($urandom_range('h10000, 'h10FFFF));
            7: v = 21'($urandom_range('h10FFFF, 'h1FFFFF));
            8: v = 21'($urandom_range(1, 'h10FFFF));
            default: v = SAT_CODE;
        endcase
        if (v == SAT_CODE)
        begin
            // long digit run, usually drives the accumulator into saturation
            repeat ($urandom_range(7, 12))
                ref_text.push_back(hex ? hex_chars[$urandom_range(0, 21)]
                                       : 8'("0") + 8'($urandom_range(0, 9)));
        end
        else
            add_number(v, hex);
        ref_text.push_back(";");
    endtask

    // Mostly well-formed references; the rest named, broken or plain noise
    task automatic send_random_reference();
        int         kind;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 60)
            add_wellformed();
        else if (kind < 70)
        begin
            ref_text.push_back("&");
            b = 8'($urandom_range(0, 255));
            ref_text.push_back((b == "#") ? 8'("a") : b);
            repeat ($urandom_range(0, 4)) ref_text.push_back(8'($urandom_range(0, 255)));
            ref_text.push_back(";");
        end
        else if (kind < 85)
        begin
            add_wellformed();
            case ($urandom_range(0, 2))
                0: ref_text[$urandom_range(0, ref_text.size() - 2)] =
                       8'($urandom_range(0, 255));
                1: repeat ($urandom_range(1, ref_text.size() - 1)) void'(ref_text.pop_back());
                default: ref_text[ref_text.size() - 1] = 8'($urandom_range(0, 255));
            endcase
        end
        else
            repeat ($urandom_range(1, 6)) ref_text.push_back(8'($urandom_range(0, 255)));
        send_ref_text();
    endtask

    // Stop offering and wait until every owed result has come back. The extra
    // edge lets the input monitor book the last character first.
    task automatic drain_results();
        char_valid <= 1'b0;
        @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hex reference in the Windows-1252 range, decimal saturation
    task automatic test_decoding();
        add_str("&#x80;");
        send_ref_text();
        add_str("&#2000000;");
        send_ref_text();
    endtask

    // Lone final byte, too short, missing semicolon, bad byte mid-reference
    task automatic test_malformed();
        add_str(";");
        send_ref_text();
        add_str("&#;");
        send_ref_text();
        add_str("&#9");
        send_ref_text();
        add_str("&#1");
        ref_text.push_back(8'hFF);
        add_str(";");
        send_ref_text();
    endtask

    task automatic test_named();
        add_str("&a;");
        send_ref_text();
    endtask

    // Receiver holds off while four-byte references keep coming, so the
    // pending slot and output register fill and final bytes get stalled
    task automatic test_backpressure();
        rx_hold_ask = 60;
        @(posedge clk);
        repeat (6)
        begin
            add_str("&#x1F600;");
            send_ref_text();
        end
    endtask

    // Random references, with a stretch where neither side idles
    task automatic test_random_mix();
        while (chars_sent < 180)
            send_random_reference();
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        while (chars_sent < 250)
            send_random_reference();
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        while (chars_sent < 330)
            send_random_reference();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_decoding();
        test_malformed();
        test_named();
        drain_results();
        test_backpressure();
        drain_results();
        test_random_mix();
        drain_results();
        repeat (8) @(posedge clk);

        $display("Sent %0d characters, checked %0d results: %0d decoded, %0d malformed,",
                 chars_sent, results_seen, refs_decoded, refs_malformed);
        $display("%0d named references, with random stalls and a long receiver hold-off",
                 refs_named);
        if (mismatch_count == 0 && decoded_q.size() == 0)
            $display("tb_numeric_char_reference_decoder: clean");
        else
            $display("tb_numeric_char_reference_decoder: errors");
        $finish;
    end

    // Run limit, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Timed out with %0d results still owed", decoded_q.size());
        $display("tb_numeric_char_reference_decoder: errors");
        $finish;
    end

endmodule

>>> numeric_char_reference_decoder.f
hw/rtl/ncr_dec_pkg.sv
hw/rtl/ncr_dec_parser.sv
hw/rtl/ncr_dec_out_stage.sv
hw/rtl/numeric_char_reference_decoder.sv
tb/sv/tb_numeric_char_reference_decoder.sv
